@@ hdl/hrds_pkg.sv @@
// Package for the HID report descriptor scanner.
// Holds parser phase codes, item tags, field widths and the result record.
// No dependencies.
package hrds_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned TAG_W    = 6;
    localparam int unsigned REM_W    = 9;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned TDATA_W  = 40;   // report_id + usage_page + usage_id

    localparam logic [BYTE_W-1:0] LONG_PREFIX = 8'hFE;
    localparam logic [1:0]        SIZE_FOUR   = 2'd3;   // size code for four data bytes

    localparam logic [TAG_W-1:0]  TAG_PAGE  = 6'h01;    // prefix 0x04
    localparam logic [TAG_W-1:0]  TAG_USAGE = 6'h02;    // prefix 0x08
    localparam logic [TAG_W-1:0]  TAG_REPID = 6'h21;    // prefix 0x84

    typedef enum logic [3:0] {
        PH_PREFIX   = 4'b0001,
        PH_SHORT    = 4'b0010,
        PH_LONG_LEN = 4'b0100,
        PH_LONG_SKP = 4'b1000
    } phase_t;

    typedef struct packed {
        logic               descriptor_done;
        logic [VALUE_W-1:0] usage_id;
        logic [VALUE_W-1:0] usage_page;
        logic [BYTE_W-1:0]  report_id;
        logic               report_id_valid;
    } result_t;

endpackage

@@ hdl/hid_report_descriptor_scanner.sv @@
// Top level of the HID report descriptor scanner.
// Byte stream in, one status transfer out per byte, two-entry output buffer.
// Depends on hrds_pkg and hrds_parser.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata/s_tlast) takes the
//   descriptor one byte per transfer; s_tlast marks the last byte.
//   Short items (0, 1, 2 or 4 data bytes) are decoded, long items (prefix
//   0xFE) are skipped by their length byte.
//   The master channel gives exactly one transfer per input byte:
//   m_tdata carries the Report ID value and the first nonzero Usage Page
//   and Usage seen so far, m_tuser flags a Report ID completed on that
//   byte, m_tlast echoes the input's last-byte mark.
//   After the last byte all parse state, the kept Usage Page and Usage
//   included, returns to its reset value.
// Timing:
//   An accepted byte's result is registered, in the output register or,
//   while that is held, in the skid register. Throughput is one byte per
//   cycle when s_tready is high; parser state moves one phase step per byte.
// Reset and stalls:
//   rst_n clears the parser and empties the output buffer.
//   When m_tready is low a result waits in the output register and one
//   more is caught in the skid register; s_tready drops only when both
//   are full, so no result is lost or repeated.
module hid_report_descriptor_scanner
    import hrds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,    // [7:0] data_byte
    input  logic               s_tlast,    // final_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,    // [7:0] report_id, [23:8] usage_page,
                                           // [39:24] usage_id
    output logic               m_tuser,    // [0] report_id_valid
    output logic               m_tlast     // descriptor_done
);

    logic    accept;
    logic    pop;
    result_t res;

    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    hrds_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .result     (res)
    );

    // Output register plus skid stage; skid drains first to keep order.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = accept;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next  = accept;
                out_data_next   = res;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.usage_id, out_data_reg.usage_page,
                       out_data_reg.report_id};
    assign m_tuser  = out_data_reg.report_id_valid;
    assign m_tlast  = out_data_reg.descriptor_done;

    // Skid stage only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // After an accepted byte m_tvalid is high in the next cycle, with that result or an older one pending.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted byte produced no pending result");

    // Report ID field is zero unless a Report ID item completed.
    a_rid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[BYTE_W-1:0] == '0))
        else $error("report_id nonzero without report_id_valid");

endmodule

@@ hdl/hrds_parser.sv @@
// Item walker for the HID report descriptor scanner.
// Holds the parse state and forms one result per accepted byte.
// Depends on hrds_pkg.
module hrds_parser
    import hrds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              final_byte,
    output result_t           result
);

    phase_t             phase_reg,  phase_next;
    logic [REM_W-1:0]   rem_reg,    rem_next;
    logic [TAG_W-1:0]   tag_reg,    tag_next;
    logic [VALUE_W-1:0] accum_reg,  accum_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [VALUE_W-1:0] page_reg,   page_next;
    logic [VALUE_W-1:0] usage_reg,  usage_next;

    logic               apply;
    logic [TAG_W-1:0]   apply_tag;
    logic [VALUE_W-1:0] apply_val;
    logic [REM_W-1:0]   rem_dec;
    logic [REM_W-1:0]   rem_new;
    logic               rid_valid;

    assign rem_dec = (rem_reg != '0) ? rem_reg - 1'b1 : '0;

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        tag_next   = tag_reg;
        accum_next = accum_reg;
        idx_next   = idx_reg;
        apply      = 1'b0;
        apply_tag  = tag_reg;
        apply_val  = '0;
        rem_new    = '0;

        case (phase_reg)
            PH_SHORT:
            begin
                if (idx_reg == 2'd0)
                begin
                    accum_next = {{(VALUE_W-BYTE_W){1'b0}}, data_byte};
                end
                else if (idx_reg == 2'd1)
                begin
                    accum_next = {data_byte, accum_reg[BYTE_W-1:0]};
                end
                idx_next = idx_reg + 1'b1;
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    apply      = 1'b1;
                    apply_val  = accum_next;
                    phase_next = PH_PREFIX;
                end
                else if (final_byte)
                begin
                    apply = 1'b1;   // cut off: value 0
                end
            end
            PH_LONG_LEN:
            begin
                // tag byte plus data bytes
                rem_next   = {1'b0, data_byte} + 1'b1;
                phase_next = PH_LONG_SKP;
            end
            PH_LONG_SKP:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_PREFIX;
                end
            end
            default:
            begin
                if (data_byte == LONG_PREFIX)
                begin
                    phase_next = PH_LONG_LEN;
                end
                else
                begin
                    tag_next   = data_byte[BYTE_W-1:2];
                    apply_tag  = data_byte[BYTE_W-1:2];
                    accum_next = '0;
                    idx_next   = '0;
                    rem_new    = (data_byte[1:0] == SIZE_FOUR) ? REM_W'(4)
                                                               : REM_W'(data_byte[1:0]);
                    rem_next   = rem_new;
                    phase_next = PH_PREFIX;
                    if (rem_new == '0 || final_byte)
                    begin
                        apply = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SHORT;
                    end
                end
            end
        endcase
    end

    // Apply a completed item to the kept fields.
    always_comb
    begin
        page_next  = page_reg;
        usage_next = usage_reg;
        rid_valid  = 1'b0;
        if (apply)
        begin
            if (apply_tag == TAG_PAGE && page_reg == '0)
            begin
                page_next = apply_val;
            end
            if (apply_tag == TAG_USAGE && usage_reg == '0)
            begin
                usage_next = apply_val;
            end
            if (apply_tag == TAG_REPID)
            begin
                rid_valid = 1'b1;
            end
        end
    end

    assign result.report_id_valid = rid_valid;
    assign result.report_id       = rid_valid ? apply_val[BYTE_W-1:0] : '0;
    assign result.usage_page      = page_next;
    assign result.usage_id        = usage_next;
    assign result.descriptor_done = final_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            rem_reg   <= '0;
            tag_reg   <= '0;
            accum_reg <= '0;
            idx_reg   <= '0;
            page_reg  <= '0;
            usage_reg <= '0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                // parser clears after the last descriptor byte
                phase_reg <= PH_PREFIX;
                rem_reg   <= '0;
                tag_reg   <= '0;
                accum_reg <= '0;
                idx_reg   <= '0;
                page_reg  <= '0;
                usage_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
                tag_reg   <= tag_next;
                accum_reg <= accum_next;
                idx_reg   <= idx_next;
                page_reg  <= page_next;
                usage_reg <= usage_next;
            end
        end
    end

endmodule
